// ===== rtl/core/idg_pkg.sv =====
// shared widths, register indexes and types of the inverse distance gain block
package idg_pkg;

    localparam int CoordW = 24;
    localparam int DiffW  = 25;
    localparam int MagW   = 24;
    localparam int SqW    = 2 * MagW;
    localparam int SumW   = SqW + 2;
    localparam int DistW  = SumW / 2;
    localparam int GainW  = 17;
    localparam int VolW   = 17;
    localparam int NumW   = GainW + DistW;
    localparam int IdxW   = 3;
    localparam int CfgW   = 25;

    // stage counts of the two iterative units
    localparam int SqrtSteps = DistW;
    localparam int DistLat   = 4 + SqrtSteps;
    localparam int DivSteps  = GainW;

    // configuration register indexes
    localparam logic [IdxW-1:0] REG_THREE_D   = 3'd0;
    localparam logic [IdxW-1:0] REG_VOLUME    = 3'd1;
    localparam logic [IdxW-1:0] REG_MOD_VOL   = 3'd2;
    localparam logic [IdxW-1:0] REG_MIN_DIST  = 3'd3;
    localparam logic [IdxW-1:0] REG_MAX_DIST  = 3'd4;

    localparam logic [GainW-1:0] GAIN_ONE = 17'h10000;

    // gain selection codes
    typedef logic [1:0] t_sel;
    localparam t_sel SEL_BASE = 2'd0;
    localparam t_sel SEL_ZERO = 2'd1;
    localparam t_sel SEL_DIV  = 2'd2;

endpackage

// ===== rtl/core/idg_if.sv =====
// item, result and configuration channel interfaces
interface idg_in_if;
    import idg_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [CoordW-1:0] source_x;
    logic signed [CoordW-1:0] source_y;
    logic signed [CoordW-1:0] source_z;
    logic signed [CoordW-1:0] listener_x;
    logic signed [CoordW-1:0] listener_y;
    logic signed [CoordW-1:0] listener_z;
    modport source (output valid, source_x, source_y, source_z,
                    listener_x, listener_y, listener_z, input ready);
    modport sink   (input valid, source_x, source_y, source_z,
                    listener_x, listener_y, listener_z, output ready);
endinterface

interface idg_out_if;
    import idg_pkg::*;
    logic             valid;
    logic             ready;
    logic [DistW-1:0] distance;
    logic [GainW-1:0] attenuated_gain;
    modport source (output valid, distance, attenuated_gain, input ready);
    modport sink   (input valid, distance, attenuated_gain, output ready);
endinterface

interface idg_cfg_if;
    import idg_pkg::*;
    logic            valid;
    logic            ready;
    logic [IdxW-1:0] index;
    logic [CfgW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/idg_dist.sv =====
// distance pipeline: differences, squares, sum and a one bit per stage square root
module idg_dist
    import idg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic signed [CoordW-1:0] i_src [3],
    input  logic signed [CoordW-1:0] i_lst [3],
    output logic                     o_valid,
    output logic [DistW-1:0]         o_dist
);

    logic signed [DiffW-1:0] r_d   [3];
    logic [MagW-1:0]         r_m   [3];
    logic [SqW-1:0]          r_sq  [3];
    logic [SumW-1:0]         r_sum;
    logic                    r_vld [DistLat];

    logic [SumW-1:0]   r_rad  [SqrtSteps];
    logic [DistW:0]    r_rem  [SqrtSteps];
    logic [DistW-1:0]  r_root [SqrtSteps];

    logic [SumW-1:0]   w_rad  [SqrtSteps];
    logic [DistW:0]    w_rem  [SqrtSteps];
    logic [DistW-1:0]  w_root [SqrtSteps];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DistLat; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < DistLat; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // differences, magnitudes, squares, sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                r_d[a]  <= DiffW'(i_src[a]) - DiffW'(i_lst[a]);
                r_m[a]  <= r_d[a][DiffW-1] ? MagW'(-r_d[a]) : MagW'(r_d[a]);
                r_sq[a] <= r_m[a] * r_m[a];
            end
            r_sum <= SumW'(r_sq[0]) + SumW'(r_sq[1]) + SumW'(r_sq[2]);
        end
    end

    // stage inputs of the root recurrence
    always_comb begin
        w_rad[0]  = r_sum;
        w_rem[0]  = '0;
        w_root[0] = '0;
        for (int k = 1; k < SqrtSteps; k++) begin
            w_rad[k]  = r_rad[k-1];
            w_rem[k]  = r_rem[k-1];
            w_root[k] = r_root[k-1];
        end
    end

    // one root bit per stage
    for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
        logic [DistW+2:0] w_sh;
        logic [DistW+2:0] w_trial;
        assign w_sh    = {w_rem[k], w_rad[k][SumW-1 -: 2]};
        assign w_trial = {1'b0, w_root[k], 2'b01};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k] <= {w_rad[k][SumW-3:0], 2'b00};
                if (w_sh >= w_trial) begin
                    r_rem[k]  <= (DistW+1)'(w_sh - w_trial);
                    r_root[k] <= {w_root[k][DistW-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= (DistW+1)'(w_sh);
                    r_root[k] <= {w_root[k][DistW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_vld[DistLat-1];
    assign o_dist  = r_root[SqrtSteps-1];

endmodule

// ===== rtl/core/idg_div.sv =====
// restoring divider, one quotient bit per stage, with distance and selection alongside
module idg_div
    import idg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NumW-1:0]  i_num,
    input  logic [DistW-1:0] i_den,
    input  logic [DistW-1:0] i_dist,
    input  t_sel             i_sel,
    output logic             o_valid,
    output logic [GainW-1:0] o_quot,
    output logic [DistW-1:0] o_dist,
    output t_sel             o_sel
);

    logic             r_vld  [DivSteps];
    logic [DistW-1:0] r_rem  [DivSteps];
    logic [GainW-1:0] r_lo   [DivSteps];
    logic [GainW-1:0] r_q    [DivSteps];
    logic [DistW-1:0] r_den  [DivSteps];
    logic [DistW-1:0] r_dist [DivSteps];
    t_sel             r_sel  [DivSteps];

    logic [DistW-1:0] w_rem  [DivSteps];
    logic [GainW-1:0] w_lo   [DivSteps];
    logic [GainW-1:0] w_q    [DivSteps];
    logic [DistW-1:0] w_den  [DivSteps];
    logic [DistW-1:0] w_dist [DivSteps];
    t_sel             w_sel  [DivSteps];

    // quotient fits in gain width, so the upper numerator bits start as remainder
    always_comb begin
        w_rem[0]  = i_num[NumW-1 -: DistW];
        w_lo[0]   = i_num[GainW-1:0];
        w_q[0]    = '0;
        w_den[0]  = i_den;
        w_dist[0] = i_dist;
        w_sel[0]  = i_sel;
        for (int k = 1; k < DivSteps; k++) begin
            w_rem[k]  = r_rem[k-1];
            w_lo[k]   = r_lo[k-1];
            w_q[k]    = r_q[k-1];
            w_den[k]  = r_den[k-1];
            w_dist[k] = r_dist[k-1];
            w_sel[k]  = r_sel[k-1];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DivSteps; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < DivSteps; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // one trial subtraction per stage
    for (genvar k = 0; k < DivSteps; k++) begin : g_div
        logic [DistW:0] w_sh;
        logic [DistW:0] w_dx;
        assign w_sh = {w_rem[k], w_lo[k][GainW-1]};
        assign w_dx = {1'b0, w_den[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lo[k]   <= {w_lo[k][GainW-2:0], 1'b0};
                r_den[k]  <= w_den[k];
                r_dist[k] <= w_dist[k];
                r_sel[k]  <= w_sel[k];
                if (w_sh >= w_dx) begin
                    r_rem[k] <= DistW'(w_sh - w_dx);
                    r_q[k]   <= {w_q[k][GainW-2:0], 1'b1};
                end else begin
                    r_rem[k] <= DistW'(w_sh);
                    r_q[k]   <= {w_q[k][GainW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_vld[DivSteps-1];
    assign o_quot  = r_q[DivSteps-1];
    assign o_dist  = r_dist[DivSteps-1];
    assign o_sel   = r_sel[DivSteps-1];

endmodule

// ===== rtl/core/inverse_distance_gain.sv =====
// top level: configuration registers, distance and divider pipelines, output register
//
//  channel   direction  payload                                       accepted when
//  i_item    in         source_x/y/z, listener_x/y/z (s24 Q15.8)      valid && ready
//  o_res     out        distance (u25 Q17.8), attenuated_gain (u17)   valid && ready
//  i_cfg     in         index (3 bits), data (25 bits)                valid && ready
//
// one item enters per cycle while the pipeline advances; a taken item passes through
// 4 arithmetic stages, 25 square root stages, 1 select stage, 17 divider stages, output
// the whole pipeline advances together and halts only while a result waits untaken
// the configuration port is always ready; reset restores the register defaults
module inverse_distance_gain
    import idg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    idg_in_if.sink     i_item,
    idg_out_if.source  o_res,
    idg_cfg_if.sink    i_cfg
);

    logic             r_three_d;
    logic [VolW-1:0]  r_volume;
    logic [VolW-1:0]  r_mod_vol;
    logic [DistW-1:0] r_min_dist;
    logic [DistW-1:0] r_max_dist;
    logic [GainW-1:0] r_base;

    logic                     w_en;
    logic signed [CoordW-1:0] w_src [3];
    logic signed [CoordW-1:0] w_lst [3];
    logic                     w_d_vld;
    logic [DistW-1:0]         w_d;
    logic [VolW-1:0]          w_vol;
    logic [2*VolW-1:0]        w_prod;
    logic [2*VolW-17:0]       w_prod_sh;

    logic             r_c_vld;
    logic [NumW-1:0]  r_c_num;
    logic [DistW-1:0] r_c_den;
    logic [DistW-1:0] r_c_dist;
    t_sel             r_c_sel;

    logic             w_q_vld;
    logic [GainW-1:0] w_quot;
    logic [DistW-1:0] w_q_dist;
    t_sel             w_q_sel;

    logic             r_out_vld;
    logic [DistW-1:0] r_out_dist;
    logic [GainW-1:0] r_out_gain;

    // configuration writes
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_three_d  <= 1'b1;
            r_volume   <= GAIN_ONE;
            r_mod_vol  <= GAIN_ONE;
            r_min_dist <= DistW'(256);
            r_max_dist <= '1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_THREE_D:  r_three_d  <= i_cfg.data[0];
                REG_VOLUME:   r_volume   <= i_cfg.data[VolW-1:0];
                REG_MOD_VOL:  r_mod_vol  <= i_cfg.data[VolW-1:0];
                REG_MIN_DIST: r_min_dist <= i_cfg.data[DistW-1:0];
                REG_MAX_DIST: r_max_dist <= i_cfg.data[DistW-1:0];
                default: ;
            endcase
        end
    end

    // base gain from the clamped volume product
    assign w_vol     = (r_volume > GAIN_ONE) ? GAIN_ONE : r_volume;
    assign w_prod    = w_vol * r_mod_vol;
    assign w_prod_sh = w_prod[2*VolW-1:16];
    always_ff @(posedge i_clk) begin
        r_base <= (w_prod_sh > (2*VolW-16)'(GAIN_ONE)) ? GAIN_ONE : GainW'(w_prod_sh);
    end

    // global advance: halt only while the output holds an untaken result
    assign w_en         = !r_out_vld || o_res.ready;
    assign i_item.ready = w_en;

    assign w_src[0] = i_item.source_x;
    assign w_src[1] = i_item.source_y;
    assign w_src[2] = i_item.source_z;
    assign w_lst[0] = i_item.listener_x;
    assign w_lst[1] = i_item.listener_y;
    assign w_lst[2] = i_item.listener_z;

    idg_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_item.valid),
        .i_src   (w_src),
        .i_lst   (w_lst),
        .o_valid (w_d_vld),
        .o_dist  (w_d)
    );

    // limit compare and numerator product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_en) begin
            r_c_vld <= w_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_num  <= r_base * r_min_dist;
            r_c_den  <= w_d;
            r_c_dist <= r_three_d ? w_d : '0;
            priority if (!r_three_d) begin
                r_c_sel <= SEL_BASE;
            end else if (w_d > r_max_dist) begin
                r_c_sel <= SEL_ZERO;
            end else if (w_d > r_min_dist) begin
                r_c_sel <= SEL_DIV;
            end else begin
                r_c_sel <= SEL_BASE;
            end
        end
    end

    idg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c_vld),
        .i_num   (r_c_num),
        .i_den   (r_c_den),
        .i_dist  (r_c_dist),
        .i_sel   (r_c_sel),
        .o_valid (w_q_vld),
        .o_quot  (w_quot),
        .o_dist  (w_q_dist),
        .o_sel   (w_q_sel)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_q_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_dist <= w_q_dist;
            unique case (w_q_sel)
                SEL_ZERO: r_out_gain <= '0;
                SEL_DIV:  r_out_gain <= w_quot;
                default:  r_out_gain <= r_base;
            endcase
        end
    end

    assign o_res.valid           = r_out_vld;
    assign o_res.distance        = r_out_dist;
    assign o_res.attenuated_gain = r_out_gain;

endmodule

// ===== rtl/core/idg_checker.sv =====
// port level checks of the inverse distance gain block and their binding
module idg_checker
    import idg_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [DistW-1:0] i_distance,
    input logic [GainW-1:0] i_gain
);

    // no result straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // gain never above unity
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_gain <= GAIN_ONE)
        else $error("gain above one");

    // input is held back only by an untaken result
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input stalled without output back-pressure");

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_distance) && $stable(i_gain))
        else $error("waiting result changed");

endmodule

bind inverse_distance_gain idg_checker u_idg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_distance  (o_res.distance),
    .i_gain      (o_res.attenuated_gain)
);
